// ===== hdl/slc_pkg.sv =====
// Shared types and codes of the survey line chaining block.
package slc_pkg;

  localparam int FIELD_W = 32;

  // Chaining mode codes; the spare code behaves as horizontal chaining.
  typedef enum logic [1:0] {
    MODE_HORIZONTAL = 2'd0,
    MODE_SLOPE      = 2'd1,
    MODE_NOCHAIN    = 2'd2
  } chain_mode_t;

  // Which difference goes through the squarer.
  typedef enum logic [1:0] {
    SQ_DY   = 2'd0,
    SQ_DXZ  = 2'd1,
    SQ_DIST = 2'd2
  } sq_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_2,
    ST_SQ_D,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_FINISH
  } slc_state_t;

  typedef struct packed {
    logic                        first_station;
    logic signed [FIELD_W-1:0]   incr_distance;
    logic signed [FIELD_W-1:0]   x_location;
    logic signed [FIELD_W-1:0]   y_location;
    logic signed [FIELD_W-1:0]   elevation;
    logic                        dist_present;
    logic                        x_present;
    logic                        y_present;
    logic                        elev_present;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]   result_value;
    logic                        result_present;
    logic                        saturated;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    sq_en;
    sq_sel_t sq_sel;
    logic    acc_init;
    logic    acc_sub;
    logic    root_init;
    logic    root_step;
    logic    commit;
  } slc_cmd_t;

  typedef struct packed {
    logic nochain;
    logic slope;
    logic math_ok;
    logic rad_neg;
  } slc_status_t;

endpackage

// ===== hdl/slc_chan_if.sv =====
// Valid/ready channel carrying one item of a given type.
interface slc_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/slc_ctrl.sv =====
// Sequencer of the survey line chaining block: squaring steps, root loop, commit.
module slc_ctrl #(
  parameter int ROOT_W = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  slc_pkg::slc_status_t status,
  output slc_pkg::slc_cmd_t   cmd
);
  import slc_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  slc_state_t       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             root_last;
  logic             out_free;

  assign root_last = (cnt == CNT_W'(ROOT_W - 1));
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.root_init) begin
      cnt <= '0;
    end else if (cmd.root_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        if (!status.math_ok) begin
          state_next = ST_FINISH;
        end else if (status.nochain || status.slope) begin
          state_next = ST_SQ_2;
        end else begin
          state_next = ST_SQ_D;
        end
      end
      ST_SQ_2: begin
        state_next = status.nochain ? ST_ROOT_INIT : ST_SQ_D;
      end
      ST_SQ_D: begin
        state_next = ST_ROOT_INIT;
      end
      ST_ROOT_INIT: begin
        state_next = status.rad_neg ? ST_FINISH : ST_ROOT;
      end
      ST_ROOT: begin
        if (root_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQ_Y: begin
        cmd.sq_en    = status.math_ok;
        cmd.sq_sel   = SQ_DY;
        cmd.acc_init = 1'b1;
        cmd.acc_sub  = !status.nochain;
      end
      ST_SQ_2: begin
        cmd.sq_en   = 1'b1;
        cmd.sq_sel  = SQ_DXZ;
        cmd.acc_sub = !status.nochain;
      end
      ST_SQ_D: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_DIST;
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/slc_datapath.sv =====
// Datapath of the survey line chaining block: differences, squarer, root, sum.
module slc_datapath #(
  parameter int VALUE_W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_data,
  input  slc_pkg::in_item_t    in_item,
  input  slc_pkg::slc_cmd_t    cmd,
  output slc_pkg::slc_status_t status,
  output slc_pkg::out_item_t   out_item
);
  import slc_pkg::*;

  localparam int VW   = VALUE_W;
  localparam int DW   = VW + 1;      // differences of two values
  localparam int RW   = VW + 1;      // square root bits
  localparam int RADW = 2 * RW;      // radicand bits
  localparam int RMW  = RW + 3;      // root remainder bits
  localparam int SW   = VW + 3;      // final sum bits
  localparam logic signed [SW-1:0] HI_S = {{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic signed [SW-1:0] LO_S = ~HI_S;

  logic [1:0] mode;
  logic       is_nochain, is_slope;

  logic signed [VW-1:0] prev_x, prev_y, prev_e;
  logic                 prev_xp, prev_yp, prev_ep;

  logic                 first_r, dp_r, xp_r, yp_r, ep_r, math_ok_r;
  logic signed [VW-1:0] dist_r, x_r, y_r, e_r;
  logic signed [DW-1:0] dy_r, dxz_r;

  logic signed [VW-1:0] dist_in, x_in, y_in, e_in;
  logic                 math_ok_in;

  logic signed [DW-1:0]   sq_op;
  logic signed [RADW-1:0] sq;
  logic signed [RADW:0]   sq_ext, acc;

  logic [RADW-1:0] rad;
  logic [RMW-1:0]  rem, rem_sh;
  logic [RMW:0]    trial;
  logic [RW-1:0]   root;

  logic signed [SW-1:0] root_ext, xd, base, sum;
  logic                 neg_dir, sat, present;
  logic signed [VW-1:0] clipped, value;

  assign is_nochain = (mode == MODE_NOCHAIN);
  assign is_slope   = (mode == MODE_SLOPE);

  assign dist_in = in_item.incr_distance[VW-1:0];
  assign x_in    = in_item.x_location[VW-1:0];
  assign y_in    = in_item.y_location[VW-1:0];
  assign e_in    = in_item.elevation[VW-1:0];

  always_comb begin
    if (is_nochain) begin
      math_ok_in = in_item.x_present && in_item.y_present && prev_xp && prev_yp;
    end else begin
      math_ok_in = in_item.dist_present && in_item.y_present && prev_xp && prev_yp &&
                   (!is_slope || (in_item.elev_present && prev_ep));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_HORIZONTAL;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  // Current station, with its differences to the stored one.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r   <= in_item.first_station;
      dp_r      <= in_item.dist_present;
      xp_r      <= in_item.x_present;
      yp_r      <= in_item.y_present;
      ep_r      <= in_item.elev_present;
      math_ok_r <= math_ok_in && !in_item.first_station;
      dist_r    <= dist_in;
      x_r       <= x_in;
      y_r       <= y_in;
      e_r       <= e_in;
      dy_r      <= DW'(y_in) - DW'(prev_y);
      dxz_r     <= is_nochain ? (DW'(x_in) - DW'(prev_x)) : (DW'(e_in) - DW'(prev_e));
    end
  end

  // One shared squarer feeding a signed accumulator.
  always_comb begin
    case (cmd.sq_sel)
      SQ_DY:   sq_op = dy_r;
      SQ_DXZ:  sq_op = dxz_r;
      SQ_DIST: sq_op = DW'(dist_r);
      default: sq_op = dy_r;
    endcase
  end

  assign sq     = sq_op * sq_op;
  assign sq_ext = (RADW + 1)'(sq);

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      if (cmd.acc_init) begin
        acc <= cmd.acc_sub ? -sq_ext : sq_ext;
      end else begin
        acc <= cmd.acc_sub ? (acc - sq_ext) : (acc + sq_ext);
      end
    end
  end

  // Digit-by-digit square root, one result bit per step.
  assign rem_sh = {rem[RMW-3:0], rad[RADW-1 -: 2]};
  assign trial  = {1'b0, rem_sh} - (RMW + 1)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad  <= acc[RADW-1:0];
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= rad << 2;
      if (!trial[RMW]) begin
        rem  <= trial[RMW-1:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  // Sign of the step, sum with the previous x (zero without chaining) and clipping.
  assign root_ext = SW'(root);
  assign neg_dir  = is_nochain ? dxz_r[DW-1] : dist_r[VW-1];
  assign xd       = neg_dir ? -root_ext : root_ext;
  assign base     = is_nochain ? '0 : SW'(prev_x);
  assign sum      = base + xd;
  assign sat      = (sum > HI_S) || (sum < LO_S);
  assign clipped  = (sum > HI_S) ? HI_S[VW-1:0] : ((sum < LO_S) ? LO_S[VW-1:0] : sum[VW-1:0]);

  always_comb begin
    if (first_r) begin
      present = is_nochain ? xp_r : dp_r;
    end else begin
      present = math_ok_r && !acc[RADW];
    end
    if (!present) begin
      value = '0;
    end else if (first_r) begin
      value = is_nochain ? x_r : dist_r;
    end else begin
      value = clipped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x  <= '0;
      prev_y  <= '0;
      prev_e  <= '0;
      prev_xp <= 1'b0;
      prev_yp <= 1'b0;
      prev_ep <= 1'b0;
    end else if (cmd.commit) begin
      if (is_nochain) begin
        prev_x  <= xp_r ? x_r : '0;
        prev_xp <= xp_r;
      end else begin
        prev_x  <= value;
        prev_xp <= present;
      end
      prev_y  <= yp_r ? y_r : '0;
      prev_yp <= yp_r;
      prev_e  <= ep_r ? e_r : '0;
      prev_ep <= ep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.result_value   <= FIELD_W'(value);
      out_item.result_present <= present;
      out_item.saturated      <= present && !first_r && sat;
    end
  end

  assign status.nochain = is_nochain;
  assign status.slope   = is_slope;
  assign status.math_ok = math_ok_r;
  assign status.rad_neg = acc[RADW];

endmodule

// ===== hdl/survey_line_chaining.sv =====
// Top level of the survey line chaining block.
//
// Stations of one survey line arrive in order on the station channel and each
// station gives exactly one result item on the result channel. In horizontal
// chaining (mode 0, and the unused code 3) the result is the previous x plus
// sign(dist) * sqrt(dist^2 - dy^2); slope chaining (mode 1) also subtracts
// dz^2; in no-chaining mode (mode 2) it is sqrt(dx^2 + dy^2), negated when
// dx is negative. A first station copies its distance or x. A missing operand
// or a negative radicand gives a nil result (value zero, present low). Values
// are signed Q23.8 taken from the low min(COORD_WIDTH, 32) bits of each field,
// and the chained sum saturates to that width. The block works on one station
// at a time. A station that needs a square root goes through the squaring
// steps and then the root loop, which produces one result bit per cycle over
// VW + 1 bits; a first station or one with a missing operand needs neither,
// and a negative radicand ends the work right after the squaring steps.
// A finished result waits in an output register; the next station is
// accepted while it waits, and its own result is held back until the earlier
// one has been taken. The mode register is written through the cfg channel,
// which is always ready, and must only be written while the block is idle.
module survey_line_chaining #(
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  slc_chan_if.sink   station,
  slc_chan_if.source result,
  slc_chan_if.sink   cfg
);
  import slc_pkg::*;

  // Width of the values that are actually computed on.
  localparam int VW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  slc_cmd_t    cmd;
  slc_status_t status;
  logic        cfg_we;

  // Configuration is taken at any time; the only register is the mode.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  slc_ctrl #(
    .ROOT_W (VW + 1)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (station.valid),
    .in_ready  (station.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  slc_datapath #(
    .VALUE_W (VW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg.payload),
    .in_item  (station.payload),
    .cmd      (cmd),
    .status   (status),
    .out_item (result.payload)
  );

  // A nil result carries a zero value and no saturation flag.
  a_nil_clean : assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.payload.result_present |->
      (result.payload.result_value == '0) && !result.payload.saturated)
    else $error("nil result with nonzero value or saturation");

  // Only one station is in flight: acceptance drops ready for the work cycles.
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    station.valid && station.ready |=> !station.ready)
    else $error("station accepted while another is in work");

  // No result can appear in the cycle right after a station is accepted.
  a_no_early_result : assert property (@(posedge clk) disable iff (rst)
    station.valid && station.ready |=> !$rose(result.valid))
    else $error("result appeared without the station being worked");

endmodule

// ===== test/survey_line_chaining_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the survey line chaining block.
module survey_line_chaining_tb;
  import slc_pkg::*;

  // Value width that the block works at; inputs are sign-extended from it.
  localparam int COORD_W = 32;
  localparam int VW = (COORD_W < 32) ? COORD_W : 32;

  // Cycles without any handshake before the run is declared hung. The slowest
  // legal gap is a result hold-off plus the work on a few stations.
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_STATIONS = 800;
  localparam int HOLD_CYCLES = 300;

  // The spare mode code, which the block treats as horizontal chaining.
  localparam chain_mode_t MODE_SPARE = chain_mode_t'(2'd3);

  // What the stimulus queue can ask the driver to do next.
  typedef enum logic [1:0] {
    STIM_STATION,
    STIM_MODE,
    STIM_DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t  kind;
    in_item_t    stn;
    chain_mode_t mode;
  } stim_t;

  logic clk = 1'b0;
  logic rst;

  slc_chan_if #(.item_t(in_item_t))    station_ch ();
  slc_chan_if #(.item_t(out_item_t))   result_ch ();
  slc_chan_if #(.item_t(chain_mode_t)) cfg_ch ();

  survey_line_chaining #(
    .COORD_WIDTH(COORD_W)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .station(station_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // 8 ns period: high for 4 ns, low for 4 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending stimulus and the results the line predictor expects, in order.
  stim_t     pending[$];
  out_item_t expected_q[$];

  // Predictor copy of the mode register and of the previous station.
  chain_mode_t line_mode = MODE_HORIZONTAL;
  longint      last_x = 0;
  longint      last_y = 0;
  longint      last_elev = 0;
  logic        last_x_ok = 1'b0;
  logic        last_y_ok = 1'b0;
  logic        last_elev_ok = 1'b0;

  // Handshakes seen at the last rising edge, for the falling-edge drivers.
  logic stn_fire = 1'b0;
  logic cfg_fire = 1'b0;

  int stations_planned = 0;
  int stations_accepted = 0;
  int results_checked = 0;
  int nil_results = 0;
  int clipped_results = 0;
  int mode_writes = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int holds_done = 0;

  // No idling in the last hundred stations, and none in every fourth block of
  // 64 stations, so that the block also sees back-to-back traffic.
  logic calm;
  assign calm = (stations_accepted + 100 > stations_planned) ||
                ((stations_accepted / 64) % 4 == 3);

  // ---------------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------------

  // Sign-extends a field from the block's value width.
  function automatic longint to_val(logic [FIELD_W-1:0] v);
    longint t;
    t = longint'(signed'(v));
    return (t <<< (64 - VW)) >>> (64 - VW);
  endfunction

  function automatic logic [127:0] mag_sq(longint v);
    logic [127:0] m;
    m = (v < 0) ? 128'(-v) : 128'(v);
    return m * m;
  endfunction

  // Floor of the square root; radicands stay below 2^66, so 35 bits suffice.
  function automatic longint root_floor(logic [127:0] rad);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 34; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= rad) r = c;
    end
    return longint'(r);
  endfunction

  // Works out the result of one station and advances the stored previous
  // station, exactly as the block must.
  function automatic out_item_t chain_station(in_item_t s);
    longint       dist_val, xin, yin, ein, value, dx, dy, xd, hi_lim, lo_lim;
    logic [127:0] d2, sub;
    logic         present, sat, nochain, slope, ok;
    out_item_t    r;
    dist_val = to_val(s.incr_distance);
    xin = to_val(s.x_location);
    yin = to_val(s.y_location);
    ein = to_val(s.elevation);
    nochain = (line_mode == MODE_NOCHAIN);
    slope = (line_mode == MODE_SLOPE);
    present = 1'b0;
    sat = 1'b0;
    value = 0;
    hi_lim = (64'sd1 <<< (VW - 1)) - 1;
    lo_lim = -hi_lim - 1;

    if (s.first_station) begin
      present = nochain ? s.x_present : s.dist_present;
      value = nochain ? xin : dist_val;
    end else if (nochain) begin
      if (s.x_present && s.y_present && last_x_ok && last_y_ok) begin
        dx = xin - last_x;
        dy = yin - last_y;
        value = root_floor(mag_sq(dx) + mag_sq(dy));
        if (dx < 0) value = -value;
        present = 1'b1;
      end
    end else begin
      ok = s.dist_present && s.y_present && last_x_ok && last_y_ok;
      if (slope) ok = ok && s.elev_present && last_elev_ok;
      if (ok) begin
        sub = mag_sq(yin - last_y);
        if (slope) sub = sub + mag_sq(ein - last_elev);
        d2 = mag_sq(dist_val);
        if (d2 >= sub) begin
          xd = root_floor(d2 - sub);
          if (dist_val < 0) xd = -xd;
          value = last_x + xd;
          present = 1'b1;
        end
      end
    end

    if (present && value > hi_lim) begin
      value = hi_lim;
      sat = 1'b1;
    end else if (present && value < lo_lim) begin
      value = lo_lim;
      sat = 1'b1;
    end
    if (!present) begin
      value = 0;
      sat = 1'b0;
    end

    // Chaining carries the computed x forward; no-chaining keeps the raw x.
    if (nochain) begin
      last_x = s.x_present ? xin : 0;
      last_x_ok = s.x_present;
    end else begin
      last_x = value;
      last_x_ok = present;
    end
    last_y = s.y_present ? yin : 0;
    last_y_ok = s.y_present;
    last_elev = s.elev_present ? ein : 0;
    last_elev_ok = s.elev_present;

    r.result_value = value[FIELD_W-1:0];
    r.result_present = present;
    r.saturated = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  function automatic bit coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  // A signed random step of up to 2^w raw units.
  function automatic longint rand_step(int w);
    longint v;
    v = longint'($urandom_range(0, 1 << w));
    return coin() ? -v : v;
  endfunction

  function automatic void add_station(bit first, longint dist_val, longint x, longint y,
                                      longint elev, bit dp, bit xp, bit yp, bit ep);
    stim_t e;
    e.kind = STIM_STATION;
    e.mode = MODE_HORIZONTAL;
    e.stn.first_station = first;
    e.stn.incr_distance = FIELD_W'(dist_val);
    e.stn.x_location = FIELD_W'(x);
    e.stn.y_location = FIELD_W'(y);
    e.stn.elevation = FIELD_W'(elev);
    e.stn.dist_present = dp;
    e.stn.x_present = xp;
    e.stn.y_present = yp;
    e.stn.elev_present = ep;
    pending.push_back(e);
    stations_planned++;
  endfunction

  function automatic void add_marker(stim_kind_t kind, chain_mode_t mode);
    stim_t e;
    e.kind = kind;
    e.mode = mode;
    e.stn = '0;
    pending.push_back(e);
  endfunction

  // One survey line: a first station and then stations that mostly chain
  // cleanly (the distance covers the offsets but for full-width coordinates), mixed with noise.
  function automatic void plan_line(chain_mode_t m, int len);
    longint px, py, pe, dy, dz, dmag;
    int     w;
    w = $urandom_range(2, 28);
    px = rand_step(28);
    py = rand_step(28);
    pe = rand_step(28);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        // Noise: random fields, random operand flags, stray first marks.
        add_station(coin(), $urandom, $urandom, $urandom, $urandom,
                    coin(), coin(), coin(), coin());
      end else begin
        dy = rand_step(w);
        dz = rand_step(w);
        px = px + rand_step(w);
        py = py + dy;
        pe = pe + dz;
        dmag = (dy < 0 ? -dy : dy) + longint'($urandom_range(0, 1 << w));
        if (m == MODE_SLOPE) dmag = dmag + (dz < 0 ? -dz : dz);
        if ($urandom_range(0, 9) == 0) begin
          // Full-width distance along a level stretch, to reach clipping.
          py = py - dy;
          pe = pe - dz;
          add_station(k == 0, $urandom, px, py, pe, 1'b1, 1'b1, 1'b1, 1'b1);
        end else if ($urandom_range(0, 15) == 0) begin
          // Full-width coordinates, mostly of interest without chaining.
          add_station(k == 0, coin() ? -dmag : dmag, $urandom, $urandom, pe,
                      1'b1, 1'b1, 1'b1, 1'b1);
        end else begin
          add_station(k == 0, coin() ? -dmag : dmag, px, py, pe, 1'b1, 1'b1, 1'b1,
                      (m == MODE_SLOPE) ? 1'b1 : coin());
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge.
  // ---------------------------------------------------------------------------

  // Station and mode-write driver. A mode write or a drain marker waits until
  // every expected result has been taken, so the block is idle by then.
  always @(negedge clk) begin : drive_stations
    logic nxt_sv;
    logic nxt_cv;
    int   send_gap;
    nxt_sv = station_ch.valid && !stn_fire;
    nxt_cv = cfg_ch.valid && !cfg_fire;
    if (!rst && !nxt_sv && !nxt_cv) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (pending.size() > 0) begin
        case (pending[0].kind)
          STIM_STATION: begin
            station_ch.payload <= pending[0].stn;
            nxt_sv = 1'b1;
            void'(pending.pop_front());
            if (!calm && $urandom_range(0, 4) == 0) send_gap = int'($urandom_range(1, 9));
          end
          STIM_MODE: begin
            if (expected_q.size() == 0) begin
              cfg_ch.payload <= pending[0].mode;
              nxt_cv = 1'b1;
              void'(pending.pop_front());
            end
          end
          STIM_DRAIN: begin
            if (expected_q.size() == 0) void'(pending.pop_front());
          end
          default: begin
            void'(pending.pop_front());
          end
        endcase
      end
    end
    station_ch.valid <= nxt_sv;
    cfg_ch.valid <= nxt_cv;
  end

  // Result receiver: short random stalls, plus two long hold-offs during
  // which the sender keeps offering stations until the block backs up.
  always @(negedge clk) begin : drive_result_ready
    int hold_left;
    int stall_left;
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_ch.ready <= 1'b0;
      end else if (holds_done < 2 &&
                   stations_accepted >= ((holds_done == 0) ? 150 : 450)) begin
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        result_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = int'($urandom_range(0, 8));
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: handshakes are sampled at the rising edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watch_channels
    out_item_t want;
    out_item_t got;
    stn_fire <= station_ch.valid && station_ch.ready;
    cfg_fire <= cfg_ch.valid && cfg_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        line_mode = cfg_ch.payload;
        mode_writes++;
      end
      if (station_ch.valid && station_ch.ready) begin
        expected_q.push_back(chain_station(station_ch.payload));
        stations_accepted++;
      end
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        results_checked++;
        if (!got.result_present) nil_results++;
        if (got.saturated) clipped_results++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with nothing expected: value %0d present %0b sat %0b",
                     $realtime, got.result_value, got.result_present, got.saturated);
        end else begin
          want = expected_q.pop_front();
          if (got.result_value !== want.result_value ||
              got.result_present !== want.result_present ||
              got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                       $realtime, results_checked, want.result_value,
                       want.result_present, want.saturated, got.result_value,
                       got.result_present, got.saturated);
          end
        end
      end
      if ((station_ch.valid && station_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Watchdog: a long stretch with no handshake on any channel means a hang.
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no item moved for %0d cycles, %0d results still expected",
             $realtime, STALL_LIMIT, expected_q.size());
    $display("survey_line_chaining test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : run_test
    int          directed_count;
    chain_mode_t m;
    rst = 1'b1;
    station_ch.valid = 1'b0;
    station_ch.payload = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = MODE_HORIZONTAL;

    // Horizontal chaining. Values are Q23.8, so 25600 is 100.0.
    add_marker(STIM_MODE, MODE_HORIZONTAL);
    add_station(1, 25600, 0, 0, 0, 1, 1, 1, 1);            // first station copies distance
    add_station(0, 128000, 0, 76800, 0, 1, 1, 1, 1);       // 500 along, 300 across
    add_station(0, -128000, 0, 76800, 0, 1, 1, 1, 1);      // backward step, same y
    add_station(0, 10, 0, 81800, 0, 1, 1, 1, 1);           // offset exceeds distance
    add_station(0, 128000, 0, 81800, 0, 1, 1, 1, 1);       // previous x is nil
    add_station(1, 25600, 0, 0, 0, 0, 1, 1, 1);            // first station, no distance
    add_station(1, 2147483392, 0, 0, 0, 1, 1, 1, 1);
    add_station(0, 2147483647, 0, 0, 0, 1, 1, 1, 1);       // clips high
    add_station(1, -2147483648, 0, 0, 0, 1, 1, 1, 1);
    add_station(0, -2147483648, 0, 0, 0, 1, 1, 1, 1);      // clips low

    // Slope chaining: a 3-4-5 triangle leaves a zero radicand.
    add_marker(STIM_MODE, MODE_SLOPE);
    add_station(1, 0, 0, 0, 0, 1, 1, 1, 1);
    add_station(0, 1280, 0, 768, 1024, 1, 1, 1, 1);
    add_station(0, 2560, 0, 768, 1024, 1, 1, 1, 0);        // elevation missing

    // No chaining: signed distance between stations.
    add_marker(STIM_MODE, MODE_NOCHAIN);
    add_station(1, 0, -7, 0, 0, 1, 1, 1, 1);               // first station copies x
    add_station(0, 0, -775, 1024, 0, 0, 1, 1, 0);          // dx negative gives -5.0
    add_station(1, 0, -2147483648, -2147483648, 0, 1, 1, 1, 1);
    add_station(0, 0, 2147483647, 2147483647, 0, 1, 1, 1, 1);    // clips high
    add_station(0, 0, -2147483648, -2147483648, 0, 1, 1, 1, 1);  // clips low
    add_station(0, 0, 5, 5, 0, 1, 0, 1, 1);                // x missing

    // The spare code chains horizontally and ignores elevation.
    add_marker(STIM_MODE, MODE_SPARE);
    add_station(1, 256, 0, 0, 0, 1, 1, 1, 1);
    add_station(0, -256, 0, 0, 0, 1, 1, 1, 1);
    add_station(0, -256, 0, 0, 77, 1, 1, 1, 0);
    add_marker(STIM_DRAIN, MODE_HORIZONTAL);
    directed_count = stations_planned;

    // Random lines, with mode changes and full drains between some of them.
    m = MODE_SPARE;
    while (stations_planned < directed_count + RANDOM_STATIONS) begin
      if ($urandom_range(0, 2) == 0) begin
        m = chain_mode_t'($urandom_range(0, 3));
        add_marker(STIM_MODE, m);
      end else if ($urandom_range(0, 7) == 0) begin
        add_marker(STIM_DRAIN, m);
      end
      plan_line(m, int'($urandom_range(3, 40)));
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending.size() != 0 || station_ch.valid || cfg_ch.valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Chained %0d stations over %0d mode writes: %0d results checked,",
             stations_accepted, mode_writes, results_checked);
    $display("%0d nil, %0d clipped; the result side held off %0d times; %0d mismatches.",
             nil_results, clipped_results, holds_done, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("survey_line_chaining test passed");
    end else begin
      $display("survey_line_chaining test failed");
    end
    $finish;
  end

endmodule
